// ===== rtl/lcd_four_bit_write_sequencer_assert.svh =====
// Assertion macros used by the checker file.
`ifndef LCD_FOUR_BIT_WRITE_SEQUENCER_ASSERT_SVH
`define LCD_FOUR_BIT_WRITE_SEQUENCER_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define LCD4_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define LCD4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/lcd4_pkg.sv =====
`default_nettype none

package lcd4_pkg;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned TicksW   = 16;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibbleW  = 4;

  localparam logic [CfgIdxW-1:0] RegRsSetup     = 8'd0;
  localparam logic [CfgIdxW-1:0] RegNibbleSetup = 8'd1;
  localparam logic [CfgIdxW-1:0] RegStrobeHigh  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegStrobeLow   = 8'd3;

  localparam logic [TicksW-1:0] RsSetupRst     = 16'd1;
  localparam logic [TicksW-1:0] NibbleSetupRst = 16'd1;
  localparam logic [TicksW-1:0] StrobeHighRst  = 16'd13;
  localparam logic [TicksW-1:0] StrobeLowRst   = 16'd3;

  localparam logic [NibbleW-1:0] NibbleMask = 4'b1111;

  typedef struct packed {
    logic [TicksW-1:0] rs_setup_ticks;
    logic [TicksW-1:0] nibble_setup_ticks;
    logic [TicksW-1:0] strobe_high_ticks;
    logic [TicksW-1:0] strobe_low_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/lcd4_if.sv =====
`default_nettype none

interface lcd4_cmd_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] send_byte;
  logic       is_character;

  modport source (output valid, output op, output send_byte, output is_character,
                  input ready);
  modport sink   (input valid, input op, input send_byte, input is_character,
                  output ready);
endinterface

interface lcd4_res_if;
  logic       valid;
  logic       ready;
  logic       rs_line;
  logic       strobe_line;
  logic [3:0] data_lines;
  logic       busy_res;
  logic       send_rejected;

  modport source (output valid, output rs_line, output strobe_line, output data_lines,
                  output busy_res, output send_rejected, input ready);
  modport sink   (input valid, input rs_line, input strobe_line, input data_lines,
                  input busy_res, input send_rejected, output ready);
endinterface

interface lcd4_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcd4_cfg_regs.sv =====
`default_nettype none

module lcd4_cfg_regs (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  lcd4_cfg_if.sink     cfg_i,
  output lcd4_pkg::cfg_t cfg_o
);
  import lcd4_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rs_setup_ticks     <= RsSetupRst;
      cfg_q.nibble_setup_ticks <= NibbleSetupRst;
      cfg_q.strobe_high_ticks  <= StrobeHighRst;
      cfg_q.strobe_low_ticks   <= StrobeLowRst;
    end else if (cfg_i.valid) begin
      // drop writes to indexes beyond the register list
      unique case (cfg_i.index)
        RegRsSetup:     cfg_q.rs_setup_ticks     <= cfg_i.data;
        RegNibbleSetup: cfg_q.nibble_setup_ticks <= cfg_i.data;
        RegStrobeHigh:  cfg_q.strobe_high_ticks  <= cfg_i.data;
        RegStrobeLow:   cfg_q.strobe_low_ticks   <= cfg_i.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcd_four_bit_write_sequencer.sv =====
// Channel  | Dir | Payload                                             | Accepted when
// cfg_i    | in  | index[7:0], data[15:0]                              | valid && ready
// cmd_i    | in  | op, send_byte[7:0], is_character                    | valid && ready
// res_o    | out | rs_line, strobe_line, data_lines[3:0], busy_res,   | valid && ready
//          |     | send_rejected                                       |
// The sequencer step runs in a single pass from the state registers into the result
// register, so one item is taken per cycle while the result is not stalled.
// cmd_i.ready is low only while a result is held and res_o.ready is low.
// rst_ni is asynchronous, active low; it clears the sequencer and restores the delay
// registers. cfg_i.ready is always high.
`default_nettype none

module lcd_four_bit_write_sequencer (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lcd4_cfg_if.sink  cfg_i,
  lcd4_cmd_if.sink  cmd_i,
  lcd4_res_if.source res_o
);
  import lcd4_pkg::*;

  typedef enum logic [2:0] {
    PhIdle,
    PhWait,
    PhRsHigh,
    PhRsLow,
    PhStrobeUp,
    PhStrobeDown,
    PhClearData,
    PhNibble
  } phase_e;

  cfg_t cfg;

  phase_e              phase_q, phase_d;
  phase_e              after_q, after_d;
  logic [TicksW-1:0]   wait_q, wait_d;
  logic [ByteW-1:0]    byte_q, byte_d;
  logic                low_due_q, low_due_d;
  logic                rs_q, rs_d;
  logic                strobe_q, strobe_d;
  logic [NibbleW-1:0]  nibble_q, nibble_d;
  logic                rejected_d;

  logic                out_valid_q;
  logic                out_rs_q;
  logic                out_strobe_q;
  logic [NibbleW-1:0]  out_data_q;
  logic                out_busy_q;
  logic                out_rej_q;
  logic                accept;

  lcd4_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign cmd_i.ready = !out_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    phase_d    = phase_q;
    after_d    = after_q;
    wait_d     = wait_q;
    byte_d     = byte_q;
    low_due_d  = low_due_q;
    rs_d       = rs_q;
    strobe_d   = strobe_q;
    nibble_d   = nibble_q;
    rejected_d = 1'b0;
    if (cmd_i.op) begin
      if (phase_q == PhIdle) begin
        byte_d    = cmd_i.send_byte;
        low_due_d = 1'b0;
        phase_d   = cmd_i.is_character ? PhRsHigh : PhRsLow;
      end else begin
        rejected_d = 1'b1;
      end
    end else begin
      unique case (phase_q)
        PhIdle: ;
        PhWait: begin
          // a count of zero or one ends the wait on this tick
          if (wait_q <= TicksW'(1)) begin
            wait_d  = '0;
            phase_d = after_q;
          end else begin
            wait_d = wait_q - TicksW'(1);
          end
        end
        PhRsHigh, PhRsLow: begin
          rs_d    = (phase_q == PhRsHigh);
          wait_d  = cfg.rs_setup_ticks;
          phase_d = PhWait;
          after_d = PhClearData;
        end
        PhClearData: begin
          nibble_d = '0;
          phase_d  = PhNibble;
        end
        PhNibble: begin
          if (low_due_q) begin
            nibble_d  = byte_q[NibbleW-1:0] & NibbleMask;
            low_due_d = 1'b0;
          end else begin
            nibble_d  = byte_q[ByteW-1:NibbleW] & NibbleMask;
            low_due_d = 1'b1;
          end
          wait_d  = cfg.nibble_setup_ticks;
          phase_d = PhWait;
          after_d = PhStrobeUp;
        end
        PhStrobeUp: begin
          strobe_d = 1'b1;
          wait_d   = cfg.strobe_high_ticks;
          phase_d  = PhWait;
          after_d  = PhStrobeDown;
        end
        PhStrobeDown: begin
          strobe_d = 1'b0;
          wait_d   = cfg.strobe_low_ticks;
          phase_d  = PhWait;
          after_d  = low_due_q ? PhClearData : PhIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      after_q      <= PhIdle;
      wait_q       <= '0;
      byte_q       <= '0;
      low_due_q    <= 1'b0;
      rs_q         <= 1'b0;
      strobe_q     <= 1'b0;
      nibble_q     <= '0;
      out_valid_q  <= 1'b0;
      out_rs_q     <= 1'b0;
      out_strobe_q <= 1'b0;
      out_data_q   <= '0;
      out_busy_q   <= 1'b0;
      out_rej_q    <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        after_q      <= after_d;
        wait_q       <= wait_d;
        byte_q       <= byte_d;
        low_due_q    <= low_due_d;
        rs_q         <= rs_d;
        strobe_q     <= strobe_d;
        nibble_q     <= nibble_d;
        out_valid_q  <= 1'b1;
        out_rs_q     <= rs_d;
        out_strobe_q <= strobe_d;
        out_data_q   <= nibble_d;
        out_busy_q   <= (phase_d != PhIdle);
        out_rej_q    <= rejected_d;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.rs_line       = out_rs_q;
  assign res_o.strobe_line   = out_strobe_q;
  assign res_o.data_lines    = out_data_q;
  assign res_o.busy_res      = out_busy_q;
  assign res_o.send_rejected = out_rej_q;

endmodule

`default_nettype wire

// ===== rtl/lcd4_checker.sv =====
`default_nettype none

`include "lcd_four_bit_write_sequencer_assert.svh"

module lcd4_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       res_valid_i,
  input wire logic       res_ready_i,
  input wire logic       rs_line_i,
  input wire logic       strobe_line_i,
  input wire logic [3:0] data_lines_i,
  input wire logic       busy_res_i,
  input wire logic       send_rejected_i
);

  // hold a stalled result
  `LCD4_ASSERT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i |=> res_valid_i && $stable({rs_line_i, strobe_line_i, data_lines_i, busy_res_i, send_rejected_i}), "result changed while stalled")

  // a rejected send leaves the transfer in progress
  `LCD4_ASSERT(a_reject_busy, clk_i, rst_ni, res_valid_i && send_rejected_i |-> busy_res_i, "send rejected while idle")

  // strobe is always low once the transfer has finished
  `LCD4_ASSERT(a_idle_strobe, clk_i, rst_ni, res_valid_i && !busy_res_i |-> !strobe_line_i, "strobe high while idle")

  // no result is offered during reset
  `LCD4_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !res_valid_i, "result valid in reset")

endmodule

bind lcd_four_bit_write_sequencer lcd4_checker u_lcd4_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .rs_line_i       (res_o.rs_line),
  .strobe_line_i   (res_o.strobe_line),
  .data_lines_i    (res_o.data_lines),
  .busy_res_i      (res_o.busy_res),
  .send_rejected_i (res_o.send_rejected)
);

`default_nettype wire

// ===== test/lcd_four_bit_write_sequencer_tb.sv =====
`timescale 1ns / 1ps

module lcd_four_bit_write_sequencer_tb;
  import lcd4_pkg::*;

  typedef enum bit {OpTick = 1'b0, OpSend = 1'b1} cmd_op_e;

  typedef enum logic [2:0] {
    StIdle, StWait, StRsHigh, StRsLow, StStrobeUp, StStrobeDown, StClearData, StNibble
  } seq_phase_e;

  typedef struct packed {
    logic               rs_line;
    logic               strobe_line;
    logic [NibbleW-1:0] data_lines;
    logic               busy_res;
    logic               send_rejected;
  } lcd_pins_t;

  // Register indexes with no register behind them.
  localparam logic [CfgIdxW-1:0] RegPastLast = 8'd4;
  localparam logic [CfgIdxW-1:0] RegIndexTop = 8'hFF;

  class lcd_bus_scoreboard;
    cfg_t              delays;
    seq_phase_e        phase;
    seq_phase_e        resume_phase;
    logic [TicksW-1:0] countdown;
    logic [ByteW-1:0]  pending_byte;
    bit                low_nibble_due;
    logic              rs_level;
    logic              strobe_level;
    logic [NibbleW-1:0] nibble_out;
    lcd_pins_t         pins_q[$];
    int unsigned       errors;

    function new();
      delays         = '{RsSetupRst, NibbleSetupRst, StrobeHighRst, StrobeLowRst};
      phase          = StIdle;
      resume_phase   = StIdle;
      countdown      = '0;
      pending_byte   = '0;
      low_nibble_due = 1'b0;
      rs_level       = 1'b0;
      strobe_level   = 1'b0;
      nibble_out     = '0;
      errors         = 0;
    endfunction

    function void set_delay(logic [CfgIdxW-1:0] idx, logic [TicksW-1:0] val);
      case (idx)
        RegRsSetup:     delays.rs_setup_ticks     = val;
        RegNibbleSetup: delays.nibble_setup_ticks = val;
        RegStrobeHigh:  delays.strobe_high_ticks  = val;
        RegStrobeLow:   delays.strobe_low_ticks   = val;
        default: ;
      endcase
    endfunction

    function void begin_wait(logic [TicksW-1:0] ticks, seq_phase_e next_phase);
      countdown    = ticks;
      phase        = StWait;
      resume_phase = next_phase;
    endfunction

    // Advance the sequencer model by one transaction and queue the pins it leaves.
    function void note_command(cmd_op_e op, logic [ByteW-1:0] send_byte, bit is_char);
      lcd_pins_t pins;
      bit        rejected;
      rejected = 1'b0;
      if (op == OpSend) begin
        if (phase == StIdle) begin
          pending_byte   = send_byte;
          low_nibble_due = 1'b0;
          phase          = is_char ? StRsHigh : StRsLow;
        end else begin
          rejected = 1'b1;
        end
      end else begin
        case (phase)
          StWait: begin
            // a count of zero ends on the first tick, same as one
            if (countdown <= 1) begin
              countdown = '0;
              phase     = resume_phase;
            end else begin
              countdown = countdown - 1'b1;
            end
          end
          StRsHigh: begin
            rs_level = 1'b1;
            begin_wait(delays.rs_setup_ticks, StClearData);
          end
          StRsLow: begin
            rs_level = 1'b0;
            begin_wait(delays.rs_setup_ticks, StClearData);
          end
          StClearData: begin
            nibble_out = '0;
            phase      = StNibble;
          end
          StNibble: begin
            if (low_nibble_due) begin
              nibble_out     = pending_byte[3:0];
              low_nibble_due = 1'b0;
            end else begin
              nibble_out     = pending_byte[7:4];
              low_nibble_due = 1'b1;
            end
            begin_wait(delays.nibble_setup_ticks, StStrobeUp);
          end
          StStrobeUp: begin
            strobe_level = 1'b1;
            begin_wait(delays.strobe_high_ticks, StStrobeDown);
          end
          StStrobeDown: begin
            strobe_level = 1'b0;
            begin_wait(delays.strobe_low_ticks, low_nibble_due ? StClearData : StIdle);
          end
          default: ;
        endcase
      end
      pins = '{rs_level, strobe_level, nibble_out, phase != StIdle, rejected};
      pins_q.push_back(pins);
    endfunction

    function void report_field(string field, logic [NibbleW-1:0] want,
                               logic [NibbleW-1:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
      end
    endfunction

    function void check_pins(lcd_pins_t got);
      lcd_pins_t want;
      if (pins_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        return;
      end
      want = pins_q.pop_front();
      report_field("rs_line",       want.rs_line,       got.rs_line);
      report_field("strobe_line",   want.strobe_line,   got.strobe_line);
      report_field("data_lines",    want.data_lines,    got.data_lines);
      report_field("busy_res",      want.busy_res,      got.busy_res);
      report_field("send_rejected", want.send_rejected, got.send_rejected);
    endfunction

    function bit busy();
      return phase != StIdle;
    endfunction

    function int unsigned pending();
      return pins_q.size();
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b1;
  bit   no_idle = 1'b0;

  lcd_bus_scoreboard sb;

  lcd4_cfg_if cfg_if ();
  lcd4_cmd_if cmd_if ();
  lcd4_res_if res_if ();

  lcd_four_bit_write_sequencer u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic program_delay(input logic [CfgIdxW-1:0] idx, input logic [TicksW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.set_delay(idx, val);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic push_item(input cmd_op_e op, input logic [ByteW-1:0] send_byte,
                           input bit is_char);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd_if.valid        <= 1'b1;
    cmd_if.op           <= op;
    cmd_if.send_byte    <= send_byte;
    cmd_if.is_character <= is_char;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(op, send_byte, is_char);
  endtask

  task automatic hold_cmd();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
  endtask

  task automatic wait_results();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Tick until the byte in flight is fully out, then drain the result queue.
  task automatic finish_transfer();
    while (sb.busy())
      push_item(OpTick, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    hold_cmd();
    wait_results();
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned done;
    cmd_op_e     op;
    bit          was_busy;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 39) == 0) begin
        hold_cmd();
        wait_results();
      end
      was_busy = sb.busy();
      if (was_busy) op = ($urandom_range(0, 11) == 0) ? OpSend : OpTick;
      else          op = ($urandom_range(0, 1) == 0) ? OpSend : OpTick;
      push_item(op, ByteW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      // idle ticks do nothing; do not count them
      if (op == OpSend || was_busy) done++;
    end
    finish_transfer();
  endtask

  task automatic program_random_delays();
    logic [TicksW-1:0] val;
    for (int r = 0; r < 4; r++) begin
      val = ($urandom_range(0, 7) == 0) ? '0 : TicksW'($urandom_range(1, 6));
      case (r)
        0: program_delay(RegRsSetup, val);
        1: program_delay(RegNibbleSetup, val);
        2: program_delay(RegStrobeHigh, val);
        default: program_delay(RegStrobeLow, val);
      endcase
    end
  endtask

  always @(posedge clk_i) begin : result_monitor
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_pins('{res_if.rs_line, res_if.strobe_line, res_if.data_lines,
                      res_if.busy_res, res_if.send_rejected});
  end

  initial begin : result_sink
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      @(negedge clk_i);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin
    #20_000_000;
    $display("lcd_four_bit_write_sequencer test failed");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni              <= 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = '0;
    cfg_if.data         = '0;
    cmd_if.valid        = 1'b0;
    cmd_if.op           = OpTick;
    cmd_if.send_byte    = '0;
    cmd_if.is_character = 1'b0;
    res_if.ready        = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset delays: idle tick, a character, a send while busy
    push_item(OpTick, 8'h00, 1'b0);
    push_item(OpSend, 8'hA5, 1'b1);
    push_item(OpSend, 8'h3C, 1'b0);
    push_item(OpTick, 8'hFF, 1'b1);
    finish_transfer();

    // zero delays behave as one; writes past the last register are dropped
    program_delay(RegRsSetup, '0);
    program_delay(RegNibbleSetup, '0);
    program_delay(RegStrobeHigh, '0);
    program_delay(RegStrobeLow, '0);
    program_delay(RegPastLast, 16'h0005);
    program_delay(RegIndexTop, 16'hFFFF);
    push_item(OpSend, 8'hFF, 1'b0);
    push_item(OpTick, 8'h00, 1'b0);
    push_item(OpTick, 8'h00, 1'b0);
    push_item(OpSend, 8'h00, 1'b1);
    finish_transfer();
    push_item(OpSend, 8'h00, 1'b1);
    finish_transfer();
    push_item(OpSend, 8'h0F, 1'b0);
    finish_transfer();
    push_item(OpSend, 8'hF0, 1'b1);
    finish_transfer();

    run_random(100);

    program_delay(RegRsSetup, RsSetupRst);
    program_delay(RegNibbleSetup, NibbleSetupRst);
    program_delay(RegStrobeHigh, StrobeHighRst);
    program_delay(RegStrobeLow, StrobeLowRst);
    run_random(100);

    repeat (4) begin
      program_random_delays();
      run_random(100);
    end

    // long waits, back to back
    no_idle = 1'b1;
    program_delay(RegRsSetup, 16'h0018);
    program_delay(RegNibbleSetup, '0);
    program_delay(RegStrobeHigh, 16'h0020);
    program_delay(RegStrobeLow, 16'h0001);
    push_item(OpSend, 8'hC3, 1'b1);
    finish_transfer();
    program_delay(RegRsSetup, 16'h0001);
    program_delay(RegNibbleSetup, 16'h0018);
    program_delay(RegStrobeHigh, '0);
    program_delay(RegStrobeLow, 16'h0020);
    push_item(OpSend, 8'h3C, 1'b0);
    finish_transfer();

    program_delay(RegRsSetup, 16'h0001);
    program_delay(RegNibbleSetup, 16'h0001);
    program_delay(RegStrobeHigh, 16'h0001);
    program_delay(RegStrobeLow, 16'h0001);
    run_random(100);
    no_idle = 1'b0;

    hold_cmd();
    wait_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0)
      $display("lcd_four_bit_write_sequencer test passed");
    else
      $display("lcd_four_bit_write_sequencer test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/lcd4_pkg.sv
rtl/lcd4_if.sv
rtl/lcd4_cfg_regs.sv
rtl/lcd_four_bit_write_sequencer.sv
rtl/lcd4_checker.sv
test/lcd_four_bit_write_sequencer_tb.sv
